// ===== sv/wwr_pkg.sv =====
// wwr_pkg: word types, pipeline control struct, calibration constants and the
// piecewise-linear color segment table for the white warmth block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wwr_pkg;

	typedef struct packed {
		logic [9:0] brightness_sample;
		logic [9:0] warmth_sample;
	} sample_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] level;
	} pixel_t;

	// load strobes for each pipeline stage register
	typedef struct packed {
		logic load1;
		logic load2;
		logic load3;
		logic load4;
	} pipe_ctrl_t;

	localparam logic [9:0] SMOOTH_RESET = 10'd512;
	localparam logic [9:0] CAL_LO       = 10'd15;
	localparam int         CAL_HI       = 1000;
	localparam int         CAL_SPAN     = CAL_HI - 15;

	// floor(t*Y/985) == (t*ceil(Y*2^K/985)) >> K for every t in 0..1008
	localparam int LVL_SHIFT  = 18;
	localparam int LVL_MUL    = (255 * (2 ** LVL_SHIFT) + CAL_SPAN - 1) / CAL_SPAN;
	localparam int LVL_PROD_W = 27;
	localparam logic [8:0] LVL_MAX = 9'd255;

	localparam int WRM_SHIFT  = 20;
	localparam int WRM_MUL    = (1023 * (2 ** WRM_SHIFT) + CAL_SPAN - 1) / CAL_SPAN;
	localparam int WRM_PROD_W = 31;
	localparam logic [10:0] WRM_MAX = 11'd1023;

	// segment spans are 146 or 147; products stay below 8192
	localparam int RCP_SHIFT  = 21;
	localparam int RCP_146    = (2 ** RCP_SHIFT + 145) / 146;
	localparam int RCP_147    = (2 ** RCP_SHIFT + 146) / 147;
	localparam int SEG_PROD_W = 14;
	localparam int RCP_PROD_W = 28;

	localparam int SEG_N = 7;
	typedef logic [2:0] seg_t;

	typedef struct packed {
		logic [7:0] y0;
		logic [5:0] dy;
		logic       dec;
	} chan_coef_t;

	typedef struct packed {
		logic [9:0] x0;
		logic       wide;
		chan_coef_t r;
		chan_coef_t g;
		chan_coef_t b;
	} seg_coef_t;

	localparam seg_coef_t SEG_TAB [SEG_N] = '{
		'{10'd0,   1'b0, '{8'd255, 6'd0,  1'b0}, '{8'd147, 6'd22, 1'b0}, '{8'd41,  6'd46, 1'b0}},
		'{10'd146, 1'b0, '{8'd255, 6'd0,  1'b0}, '{8'd169, 6'd28, 1'b0}, '{8'd87,  6'd56, 1'b0}},
		'{10'd292, 1'b0, '{8'd255, 6'd0,  1'b0}, '{8'd197, 6'd17, 1'b0}, '{8'd143, 6'd27, 1'b0}},
		'{10'd438, 1'b1, '{8'd255, 6'd0,  1'b0}, '{8'd214, 6'd27, 1'b0}, '{8'd170, 6'd54, 1'b0}},
		'{10'd585, 1'b0, '{8'd255, 6'd10, 1'b1}, '{8'd241, 6'd2,  1'b0}, '{8'd224, 6'd31, 1'b0}},
		'{10'd731, 1'b0, '{8'd245, 6'd20, 1'b1}, '{8'd243, 6'd8,  1'b1}, '{8'd255, 6'd0,  1'b0}},
		'{10'd877, 1'b0, '{8'd225, 6'd24, 1'b1}, '{8'd235, 6'd9,  1'b1}, '{8'd255, 6'd0,  1'b0}}
	};

	function automatic seg_t seg_of(input logic [9:0] w);
		seg_t s;
		s = '0;
		for (int i = 1; i < SEG_N; i++) begin
			if (w >= SEG_TAB[i].x0) begin
				s = 3'(i);
			end
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== sv/white_warmth_to_rgb_with_dimmer.sv =====
// white_warmth_to_rgb_with_dimmer: top level, pipeline handshake control and
// the level and color paths. Depends on wwr_pkg, wwr_level, wwr_color.
//
//   channel  | direction | word                                  | handshake
//   ---------+-----------+---------------------------------------+---------------------------
//   sample   | in        | brightness_sample, warmth_sample      | sample_valid/sample_ready
//   pixel    | out       | red, green, blue, level               | pixel_valid/pixel_ready
//
// Four register stages: one word per cycle while pixel_ready is not holding the output.
// The filter register updates on accept, so each accepted sample sees the filter left by the one before it.
// Reset clears the stage valids and loads the filter with 512.
// A stalled pixel holds its stage; earlier stages keep filling until all are full.
`timescale 1ns / 1ps
`default_nettype none

module white_warmth_to_rgb_with_dimmer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  wwr_pkg::sample_t sample,
	output logic             pixel_valid,
	input  logic             pixel_ready,
	output wwr_pkg::pixel_t  pixel
);
	import wwr_pkg::*;

	logic       v1_q, v2_q, v3_q, v4_q;
	pipe_ctrl_t ctrl;
	logic [7:0] red, green, blue, level;

	always_comb begin
		ctrl.load4   = v3_q & (~v4_q | pixel_ready);
		ctrl.load3   = v2_q & (~v3_q | ctrl.load4);
		ctrl.load2   = v1_q & (~v2_q | ctrl.load3);
		sample_ready = ~v1_q | ctrl.load2;
		ctrl.load1   = sample_valid & sample_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			v1_q <= ctrl.load1 | (v1_q & ~ctrl.load2);
			v2_q <= ctrl.load2 | (v2_q & ~ctrl.load3);
			v3_q <= ctrl.load3 | (v3_q & ~ctrl.load4);
			v4_q <= ctrl.load4 | (v4_q & ~pixel_ready);
		end
	end

	assign pixel_valid = v4_q;
	assign pixel       = '{red: red, green: green, blue: blue, level: level};

	wwr_level u_level (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.brightness (sample.brightness_sample),
		.level      (level)
	);

	wwr_color u_color (
		.clk    (clk),
		.ctrl   (ctrl),
		.warmth (sample.warmth_sample),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule

`default_nettype wire

// ===== sv/wwr_level.sv =====
// wwr_level: brightness smoothing filter and calibrated level path, stages 1..4.
// Depends on wwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wwr_level (
	input  logic                clk,
	input  logic                arst_n,
	input  wwr_pkg::pipe_ctrl_t ctrl,
	input  logic [9:0]          brightness,
	output logic [7:0]          level
);
	import wwr_pkg::*;

	logic [9:0]            smooth_q;
	logic [12:0]           sum;
	logic [9:0]            smooth_s1;
	logic [9:0]            span;
	logic [LVL_PROD_W-1:0] prod;
	logic [8:0]            scaled;
	logic [7:0]            level_s2;
	logic [7:0]            level_s3;
	logic [7:0]            level_s4;

	// 7/8 average: (8s - s + x) / 8
	assign sum = {smooth_q, 3'b000} - {3'b000, smooth_q} + {3'b000, brightness};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= SMOOTH_RESET;
		end else if (ctrl.load1) begin
			smooth_q <= sum[12:3];
		end
	end

	assign span   = (smooth_s1 > CAL_LO) ? (smooth_s1 - CAL_LO) : '0;
	assign prod   = LVL_PROD_W'(span) * LVL_PROD_W'(LVL_MUL);
	assign scaled = prod[LVL_SHIFT+8:LVL_SHIFT];

	always_ff @(posedge clk) begin
		if (ctrl.load1) begin
			smooth_s1 <= sum[12:3];
		end
		if (ctrl.load2) begin
			level_s2 <= (scaled > LVL_MAX) ? LVL_MAX[7:0] : scaled[7:0];
		end
		if (ctrl.load3) begin
			level_s3 <= level_s2;
		end
		if (ctrl.load4) begin
			level_s4 <= level_s3;
		end
	end

	assign level = level_s4;

endmodule

`default_nettype wire

// ===== sv/wwr_color.sv =====
// wwr_color: warmth rescale and seven-segment color interpolation, stages 1..4.
// Depends on wwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wwr_color (
	input  logic                clk,
	input  wwr_pkg::pipe_ctrl_t ctrl,
	input  logic [9:0]          warmth,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue
);
	import wwr_pkg::*;

	logic [9:0]            warmth_s1;
	logic [9:0]            wspan;
	logic [WRM_PROD_W-1:0] wprod;
	logic [10:0]           wscaled;
	logic [9:0]            w_s2;

	seg_t                  seg;
	seg_coef_t             cf2;
	logic [9:0]            offs;
	seg_t                  seg_s3;
	logic [SEG_PROD_W-1:0] pr_s3, pg_s3, pb_s3;

	seg_coef_t             cf3;
	logic [SEG_PROD_W-1:0] rcp;
	logic [RCP_PROD_W-1:0] qr_full, qg_full, qb_full;
	logic [7:0]            red_s4, green_s4, blue_s4;

	// y0 +/- floor(d*|dy|/span), which matches truncation toward zero
	function automatic logic [7:0] chan_val(input chan_coef_t c, input logic [6:0] q);
		logic [7:0] q8;
		q8 = {1'b0, q};
		return c.dec ? (c.y0 - q8) : (c.y0 + q8);
	endfunction

	assign wspan   = (warmth_s1 > CAL_LO) ? (warmth_s1 - CAL_LO) : '0;
	assign wprod   = WRM_PROD_W'(wspan) * WRM_PROD_W'(WRM_MUL);
	assign wscaled = wprod[WRM_SHIFT+10:WRM_SHIFT];

	assign seg  = seg_of(w_s2);
	assign cf2  = SEG_TAB[seg];
	assign offs = w_s2 - cf2.x0;

	assign cf3     = SEG_TAB[seg_s3];
	assign rcp     = cf3.wide ? SEG_PROD_W'(RCP_147) : SEG_PROD_W'(RCP_146);
	assign qr_full = RCP_PROD_W'(pr_s3) * RCP_PROD_W'(rcp);
	assign qg_full = RCP_PROD_W'(pg_s3) * RCP_PROD_W'(rcp);
	assign qb_full = RCP_PROD_W'(pb_s3) * RCP_PROD_W'(rcp);

	always_ff @(posedge clk) begin
		if (ctrl.load1) begin
			warmth_s1 <= warmth;
		end
		if (ctrl.load2) begin
			w_s2 <= (wscaled > WRM_MAX) ? WRM_MAX[9:0] : wscaled[9:0];
		end
		if (ctrl.load3) begin
			seg_s3 <= seg;
			pr_s3  <= SEG_PROD_W'(offs[7:0]) * SEG_PROD_W'(cf2.r.dy);
			pg_s3  <= SEG_PROD_W'(offs[7:0]) * SEG_PROD_W'(cf2.g.dy);
			pb_s3  <= SEG_PROD_W'(offs[7:0]) * SEG_PROD_W'(cf2.b.dy);
		end
		if (ctrl.load4) begin
			red_s4   <= chan_val(cf3.r, qr_full[RCP_SHIFT+6:RCP_SHIFT]);
			green_s4 <= chan_val(cf3.g, qg_full[RCP_SHIFT+6:RCP_SHIFT]);
			blue_s4  <= chan_val(cf3.b, qb_full[RCP_SHIFT+6:RCP_SHIFT]);
		end
	end

	assign red   = red_s4;
	assign green = green_s4;
	assign blue  = blue_s4;

endmodule

`default_nettype wire
